### rtl/rpu_pkg.sv
// Shared types and constants for the Rprop parameter update block.
`timescale 1ns / 1ps
package rpu_pkg;

    localparam int DEPTH      = 1024;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STAGES = VAL_W;
    localparam int STATE_W    = CFG_W + 3 * VAL_W + 1;

    localparam logic [CFG_W-1:0] SIZE_MAX = {CFG_W{1'b1}};
    localparam logic [VAL_W-1:0] RECIP_5  = 32'hCCCC_CCCD;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 2'd2;

    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_HOLD,
        KIND_GROW,
        KIND_CURVE,
        KIND_NONE
    } kind_t;

    typedef enum logic [1:0] {
        CURVE_KEEP,
        CURVE_ZERO,
        CURVE_QUOT
    } curve_t;

    // Per-item data that travels alongside the divider stages.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [VAL_W-1:0] grad;
        logic [VAL_W-1:0] pos;
        logic [VAL_W-1:0] prev;
        logic [CFG_W-1:0] size_old;
        logic [VAL_W-1:0] lstep_old;
        logic             act_old;
        kind_t            kind;
        curve_t           curve;
        logic [CFG_W-1:0] grow;
        logic             ovf;
    } side_t;

endpackage

### rtl/rpu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/rpu_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rpu_div_pipe
    import rpu_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [2*VAL_W-1:0] dividend,
    input  logic [VAL_W:0]     divisor,
    output logic [VAL_W-1:0]   quotient
);

    logic [VAL_W:0]   rem_reg [DIV_STAGES];
    logic [VAL_W-1:0] lo_reg  [DIV_STAGES];
    logic [VAL_W-1:0] q_reg   [DIV_STAGES];
    logic [VAL_W:0]   d_reg   [DIV_STAGES];

    logic [VAL_W:0]   rem_next [DIV_STAGES];
    logic [VAL_W-1:0] lo_next  [DIV_STAGES];
    logic [VAL_W-1:0] q_next   [DIV_STAGES];
    logic [VAL_W:0]   d_next   [DIV_STAGES];

    always_comb begin
        logic [VAL_W:0]   rem_in;
        logic [VAL_W-1:0] lo_in;
        logic [VAL_W-1:0] q_in;
        logic [VAL_W:0]   d_in;
        logic [VAL_W+1:0] trial;
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                rem_in = {1'b0, dividend[2*VAL_W-1:VAL_W]};
                lo_in  = dividend[VAL_W-1:0];
                q_in   = '0;
                d_in   = divisor;
            end else begin
                rem_in = rem_reg[i-1];
                lo_in  = lo_reg[i-1];
                q_in   = q_reg[i-1];
                d_in   = d_reg[i-1];
            end
            trial = {rem_in, lo_in[VAL_W-1]};
            if (trial >= {1'b0, d_in}) begin
                rem_next[i] = (VAL_W+1)'(trial - {1'b0, d_in});
                q_next[i]   = {q_in[VAL_W-2:0], 1'b1};
            end else begin
                rem_next[i] = trial[VAL_W:0];
                q_next[i]   = {q_in[VAL_W-2:0], 1'b0};
            end
            lo_next[i] = {lo_in[VAL_W-2:0], 1'b0};
            d_next[i]  = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= lo_next[i];
                q_reg[i]   <= q_next[i];
                d_reg[i]   <= d_next[i];
            end
        end
    end

    assign quotient = q_reg[DIV_STAGES-1];

endmodule

### rtl/rprop_parameter_update_top.sv
// Top level of the Rprop parameter update pipeline.
`timescale 1ns / 1ps
// Streams one parameter per transaction and returns its updated position and the step
// taken. The pipeline is 35 stages deep (state read, multiply, 32 divider stages, output
// register) and accepts one transaction per cycle when not stalled. Per-parameter state
// sits in a 1024-entry RAM addressed by an internal element counter; a transaction waits
// at the input while an earlier transaction for the same element is still in flight, so
// short passes (below 35 elements) run below the full rate, limited by the read-modify-write
// loop through the RAM. The whole pipeline stalls only while a finished result waits at
// the output. Per-parameter state is undefined until its first pass.
module rprop_parameter_update_top
    import rpu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_grad_value,
    input  logic signed [VAL_W-1:0] s_position,
    input  logic                    s_last_element,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_new_position,
    output logic signed [VAL_W-1:0] m_step_taken
);

    logic [CFG_W-1:0] step_max_reg, step_min_reg, initial_step_reg;
    logic [IDX_W-1:0] elem_idx_reg;
    logic [1:0]       pass_reg;

    logic en, accept, hazard;

    // Stage 1: state read
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [VAL_W-1:0] s1_grad_reg, s1_pos_reg;
    logic             s1_last_reg;
    logic [1:0]       s1_pass_reg;
    logic [STATE_W-1:0] ram_rdata;

    // Stage 2: products
    logic               s2_valid_reg;
    side_t              s2_side_reg;
    logic [1:0]         s2_pass_reg;
    logic               s2_scpos_reg, s2_scneg_reg;
    logic [2*VAL_W-1:0] s2_prod_reg, s2_q5_reg;
    logic [VAL_W:0]     s2_dmag_reg;
    logic               s2_dpos_reg, s2_dneg_reg;

    logic  pipe_valid_reg [DIV_STAGES];
    side_t pipe_side_reg  [DIV_STAGES];

    logic [VAL_W-1:0] quotient;

    logic             m_valid_reg;
    logic [VAL_W-1:0] m_pos_reg, m_step_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && !hazard;
    assign accept  = s_valid && s_ready;

    always_comb begin
        hazard = (s1_valid_reg && s1_idx_reg == elem_idx_reg)
              || (s2_valid_reg && s2_side_reg.idx == elem_idx_reg);
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (pipe_valid_reg[i] && pipe_side_reg[i].idx == elem_idx_reg) begin
                hazard = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_max_reg     <= CFG_W'(8388608);
            step_min_reg     <= CFG_W'(1);
            initial_step_reg <= CFG_W'(1678);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP_MAX:     step_max_reg     <= cfg_wr_data;
                REG_STEP_MIN:     step_min_reg     <= cfg_wr_data;
                REG_INITIAL_STEP: initial_step_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_idx_reg <= '0;
            pass_reg     <= '0;
        end else if (accept) begin
            if (s_last_element) begin
                elem_idx_reg <= '0;
                if (pass_reg != 2'd2) begin
                    pass_reg <= pass_reg + 2'd1;
                end
            end else if (elem_idx_reg == IDX_W'(DEPTH - 1)) begin
                elem_idx_reg <= '0;
            end else begin
                elem_idx_reg <= elem_idx_reg + IDX_W'(1);
            end
        end
    end

    // Write-back signals from the last divider stage.
    logic               wb_we;
    logic [STATE_W-1:0] wb_data;
    side_t              fs;

    rpu_ram #(
        .WIDTH (STATE_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (wb_we),
        .waddr (fs.idx),
        .wdata (wb_data),
        .re    (accept),
        .raddr (elem_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_idx_reg  <= elem_idx_reg;
            s1_grad_reg <= s_grad_value;
            s1_pos_reg  <= s_position;
            s1_last_reg <= s_last_element;
            s1_pass_reg <= pass_reg;
        end
    end

    // Stage 1 logic: unpack state, sign tests, multiplies.
    logic [CFG_W-1:0] rd_size;
    logic [VAL_W-1:0] rd_lstep, rd_prev, rd_older;
    logic             rd_act;
    logic [VAL_W-1:0] mag_g, mag_ls, size_p2;
    logic [VAL_W:0]   diff, dmag;
    logic             g_pos, g_neg, p_pos, p_neg;
    side_t            s1_side;

    always_comb begin
        {rd_size, rd_lstep, rd_act, rd_prev, rd_older} = ram_rdata;
        mag_g   = s1_grad_reg[VAL_W-1] ? (~s1_grad_reg + VAL_W'(1)) : s1_grad_reg;
        mag_ls  = rd_lstep[VAL_W-1] ? (~rd_lstep + VAL_W'(1)) : rd_lstep;
        diff    = {s1_grad_reg[VAL_W-1], s1_grad_reg} - {rd_older[VAL_W-1], rd_older};
        dmag    = diff[VAL_W] ? (~diff + (VAL_W+1)'(1)) : diff;
        size_p2 = {1'b0, rd_size} + VAL_W'(2);
        g_neg   = s1_grad_reg[VAL_W-1];
        g_pos   = !g_neg && (s1_grad_reg != '0);
        p_neg   = rd_prev[VAL_W-1];
        p_pos   = !p_neg && (rd_prev != '0);

        s1_side           = '0;
        s1_side.idx       = s1_idx_reg;
        s1_side.last      = s1_last_reg;
        s1_side.grad      = s1_grad_reg;
        s1_side.pos       = s1_pos_reg;
        s1_side.prev      = rd_prev;
        s1_side.size_old  = rd_size;
        s1_side.lstep_old = rd_lstep;
        s1_side.act_old   = rd_act;
        s1_side.kind      = KIND_NONE;
        s1_side.curve     = CURVE_KEEP;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg  <= s1_side;
            s2_pass_reg  <= s1_pass_reg;
            s2_scpos_reg <= rd_act && ((g_pos && p_pos) || (g_neg && p_neg));
            s2_scneg_reg <= rd_act && ((g_pos && p_neg) || (g_neg && p_pos));
            s2_prod_reg  <= (2*VAL_W)'(mag_g) * (2*VAL_W)'(mag_ls);
            s2_q5_reg    <= (2*VAL_W)'(size_p2) * (2*VAL_W)'(RECIP_5);
            s2_dmag_reg  <= dmag;
            s2_dpos_reg  <= !diff[VAL_W] && (diff != '0);
            s2_dneg_reg  <= diff[VAL_W];
        end
    end

    // Stage 2 logic: classify the update and prepare the divider.
    side_t          s2_side;
    logic [VAL_W-1:0] grow_sum;
    logic           ls_zero, ls_pos, ls_neg;

    always_comb begin
        s2_side  = s2_side_reg;
        // (6*size + 2) / 5 equals size + (size + 2) / 5.
        grow_sum = {1'b0, s2_side_reg.size_old} + VAL_W'(s2_q5_reg[2*VAL_W-1:34]);
        s2_side.grow = grow_sum[VAL_W-1] ? SIZE_MAX : grow_sum[CFG_W-1:0];
        s2_side.ovf  = {1'b0, s2_prod_reg[2*VAL_W-1:VAL_W]} >= s2_dmag_reg;

        ls_zero = s2_side_reg.lstep_old == '0;
        ls_neg  = s2_side_reg.lstep_old[VAL_W-1];
        ls_pos  = !ls_neg && !ls_zero;

        if (s2_pass_reg == 2'd0) begin
            s2_side.kind = KIND_INIT;
        end else if (s2_scneg_reg) begin
            s2_side.kind = KIND_HOLD;
        end else if (s2_scpos_reg) begin
            s2_side.kind = KIND_GROW;
        end else if (s2_pass_reg == 2'd2) begin
            s2_side.kind = KIND_CURVE;
        end else begin
            s2_side.kind = KIND_NONE;
        end

        if (ls_zero) begin
            s2_side.curve = s2_dpos_reg ? CURVE_ZERO : CURVE_KEEP;
        end else if ((s2_dpos_reg && ls_pos) || (s2_dneg_reg && ls_neg)) begin
            s2_side.curve = CURVE_QUOT;
        end else begin
            s2_side.curve = CURVE_KEEP;
        end
    end

    rpu_div_pipe u_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (s2_prod_reg),
        .divisor  (s2_dmag_reg),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                pipe_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            pipe_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++) begin
                pipe_valid_reg[i] <= pipe_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_side_reg[0] <= s2_side;
            for (int i = 1; i < DIV_STAGES; i++) begin
                pipe_side_reg[i] <= pipe_side_reg[i-1];
            end
        end
    end

    // Final stage: pick the step size, clamp, apply, and write state back.
    logic [CFG_W-1:0] q_sat, size_sel, size_fin;
    logic [VAL_W-1:0] step_fin, step_neg, step_pos;
    logic             moved, act_fin, fg_pos, fg_neg;
    logic [VAL_W:0]   pos_sum;
    logic [VAL_W-1:0] pos_fin;

    always_comb begin
        fs       = pipe_side_reg[DIV_STAGES-1];
        q_sat    = (fs.ovf || quotient[VAL_W-1]) ? SIZE_MAX : quotient[CFG_W-1:0];
        fg_neg   = fs.grad[VAL_W-1];
        fg_pos   = !fg_neg && (fs.grad != '0);
        size_sel = fs.size_old;
        size_fin = fs.size_old;
        moved    = 1'b0;
        act_fin  = fs.act_old;

        case (fs.curve)
            CURVE_ZERO: size_sel = '0;
            CURVE_QUOT: size_sel = q_sat;
            default:    size_sel = fs.size_old;
        endcase

        case (fs.kind)
            KIND_INIT: begin
                size_fin = initial_step_reg;
                moved    = 1'b1;
                act_fin  = 1'b1;
            end
            KIND_HOLD: begin
                act_fin = 1'b0;
            end
            KIND_GROW: begin
                size_fin = fs.grow;
                if (!fs.last && size_fin > step_max_reg) begin
                    size_fin = step_max_reg;
                end
                moved = 1'b1;
            end
            KIND_CURVE: begin
                size_fin = size_sel;
                if (size_fin < step_min_reg) begin
                    size_fin = step_min_reg;
                end
                if (!fs.last && size_fin > step_max_reg) begin
                    size_fin = step_max_reg;
                end
                moved   = 1'b1;
                act_fin = 1'b1;
            end
            default: ;
        endcase

        step_pos = {1'b0, size_fin};
        step_neg = ~step_pos + VAL_W'(1);
        if (!moved) begin
            step_fin = '0;
        end else if (fs.kind == KIND_INIT || fg_pos) begin
            step_fin = step_neg;
        end else if (fg_neg) begin
            step_fin = step_pos;
        end else begin
            step_fin = '0;
        end

        pos_sum = {fs.pos[VAL_W-1], fs.pos} + {step_fin[VAL_W-1], step_fin};
        if (pos_sum[VAL_W] != pos_sum[VAL_W-1]) begin
            pos_fin = pos_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, SIZE_MAX};
        end else begin
            pos_fin = pos_sum[VAL_W-1:0];
        end

        wb_we   = en && pipe_valid_reg[DIV_STAGES-1];
        wb_data = {moved ? size_fin : fs.size_old,
                   moved ? step_fin : fs.lstep_old,
                   act_fin, fs.grad, fs.prev};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= pipe_valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_pos_reg  <= pos_fin;
            m_step_reg <= step_fin;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_new_position = m_pos_reg;
    assign m_step_taken   = m_step_reg;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while the pipeline is stalled");

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted transaction did not reach the first stage");

    a_no_rmw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && wb_we) |-> (fs.idx != elem_idx_reg))
        else $error("state read and write-back hit the same element");

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && pipe_valid_reg[DIV_STAGES-1]) |=> m_valid)
        else $error("final stage transaction lost before the output");

endmodule
